// File: rtl/core/fmwt_pkg.sv
// ----------------------------------------------------------------------------
// fmwt_pkg
// Shared types and constants of the FM wavetable sound channel.
// ----------------------------------------------------------------------------
package fmwt_pkg;

    localparam int WAVE_DEPTH_DEF = 64;

    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [1:0] CFG_CPS   = 2'd0;
    localparam logic [1:0] CFG_CPF   = 2'd1;
    localparam logic [1:0] CFG_OMODE = 2'd2;
    localparam logic [1:0] CFG_OSHFT = 2'd3;

    localparam logic [1:0] OFS_WAVE = 2'd2;
    localparam logic [1:0] OFS_OUT  = 2'd3;

    localparam logic [15:0] ADDR_CWAVE = 16'h4040;
    localparam logic [15:0] ADDR_REGS  = 16'h4080;
    localparam logic [15:0] ADDR_OP1   = 16'h4084;
    localparam logic [15:0] ADDR_READ  = 16'h4090;

    localparam logic [31:0] FREQ_MIN = 32'h20;

    // Classified command handed from the front end to the execution unit.
    typedef enum logic [2:0] {
        CMD_NONE = 3'b001,
        CMD_READ = 3'b010,
        CMD_TICK = 3'b100
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] read_data;
    } cmd_t;

    function automatic logic [3:0] step_value(input logic [2:0] code);
        logic [3:0] r;
        unique case (code)
            3'd0: r = 4'sd0;
            3'd1: r = 4'sd2;
            3'd2: r = 4'sd4;
            3'd3: r = 4'sd6;
            3'd4: r = 4'b1000;
            3'd5: r = 4'b1010;
            3'd6: r = 4'b1100;
            default: r = 4'b1110;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/fmwt_front.sv
// ----------------------------------------------------------------------------
// fmwt_front
// Accepts bus transactions, applies register writes and queues commands.
// ----------------------------------------------------------------------------
module fmwt_front #(
    parameter int WAVE_DEPTH = fmwt_pkg::WAVE_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic [15:0]        s_address,
    input  logic [7:0]         s_value,
    input  logic [1:0]         offset_mode,
    input  logic [3:0]         offset_shift,
    input  logic               q_full,
    input  logic               q_not_empty,
    output logic               q_push,
    output fmwt_pkg::cmd_t     q_data,
    input  logic               busy,
    input  logic               exec_active,
    // register state to the back end
    output logic [22:0]        freq [2],
    output logic [31:0]        ofs_freq,
    output logic [31:0]        ofs_wave,
    output logic [31:0]        ofs_out,
    output logic [5:0]         frate [2],
    output logic               fdir_up [2],
    output logic               fdis [2],
    output logic [5:0]         vol_load [2],
    output logic               vol_load_en [2],
    output logic [1:0]         level [2],
    output logic               dis [2],
    output logic               dis2 [2],
    output logic               cw_we,
    output logic [$clog2(WAVE_DEPTH)-1:0] cw_addr,
    output logic [5:0]         cw_data,
    output logic               mw_we,
    output logic [$clog2(WAVE_DEPTH)-1:0] mw_addr,
    output logic [3:0]         mw_data
);
    import fmwt_pkg::*;
    localparam int AW = $clog2(WAVE_DEPTH);

    logic [7:0]  mirror_reg [16];
    logic [22:0] freq_reg [2];
    logic [31:0] ofs_freq_reg, ofs_wave_reg, ofs_out_reg;
    logic [5:0]  frate_reg [2];
    logic        fdir_reg [2], fdis_reg [2], dis_reg [2], dis2_reg [2];
    logic [1:0]  level_reg [2];
    logic [AW-1:0] mwi_reg;
    logic        mw_second_reg;
    logic [3:0]  mw_val_reg;

    logic acc, is_wr, in_regs, op_sel, wr_hold;
    logic [31:0] dat, sh_l, sh_r;
    logic [3:0]  lo;

    // A write changes state that queued or running ticks still use, so it
    // waits until the queue is empty and the execution unit is idle.
    // Writes to the modulator table store two entries, one after the other.
    assign is_wr   = s_req_type == REQ_WRITE;
    assign wr_hold = is_wr && (q_not_empty || exec_active);
    assign s_ready = !q_full && !mw_second_reg && !busy && !wr_hold;
    assign acc     = s_valid && s_ready;
    assign in_regs = s_address >= ADDR_REGS && s_address < ADDR_READ;
    assign op_sel  = s_address >= ADDR_OP1;
    assign lo      = s_address[3:0];

    assign dat  = (s_value[6:0] < 7'h60) ? {25'd0, s_value[6:0]}
                                          : ({25'd0, s_value[6:0]} - 32'h80);
    assign sh_l = dat << offset_shift;
    assign sh_r = $unsigned($signed(dat) >>> offset_shift);

    always_comb begin
        q_push = acc;
        q_data.read_data = 8'd0;
        q_data.kind = CMD_NONE;
        if (s_req_type == REQ_READ) begin
            q_data.kind = CMD_READ;
            if (s_address >= ADDR_READ && s_address <= 16'h409F) begin
                q_data.read_data = mirror_reg[lo];
            end
        end else if (s_req_type == REQ_TICK) begin
            q_data.kind = CMD_TICK;
        end
    end

    assign cw_we   = acc && is_wr && s_address >= ADDR_CWAVE && s_address < ADDR_REGS;
    assign cw_addr = s_address[AW-1:0];
    assign cw_data = s_value[5:0] ^ 6'h20;

    assign mw_we   = (acc && is_wr && in_regs && lo == 4'd8) || mw_second_reg;
    assign mw_addr = mwi_reg;
    assign mw_data = mw_second_reg ? mw_val_reg : step_value(s_value[2:0]);

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            vol_load[i]    = s_value[5:0];
            vol_load_en[i] = acc && is_wr && in_regs && s_value[7] &&
                             lo == (i == 0 ? 4'd0 : 4'd4);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) mirror_reg[i] <= 8'd0;
            for (int i = 0; i < 2; i++) begin
                freq_reg[i] <= '0; frate_reg[i] <= '0; fdir_reg[i] <= 1'b0;
                fdis_reg[i] <= 1'b0; dis_reg[i] <= 1'b0; dis2_reg[i] <= 1'b0;
                level_reg[i] <= '0;
            end
            ofs_freq_reg <= '0; ofs_wave_reg <= '0; ofs_out_reg <= '0;
            mwi_reg <= '0; mw_second_reg <= 1'b0; mw_val_reg <= '0;
        end else begin
            if (mw_second_reg) begin
                mw_second_reg <= 1'b0;
                mwi_reg <= mwi_reg + AW'(1);
            end
            if (acc && is_wr && in_regs) begin
                mirror_reg[lo] <= s_value;
                unique case (lo)
                    4'd0, 4'd4: begin
                        fdis_reg[op_sel] <= s_value[7];
                        if (!s_value[7]) begin
                            fdir_reg[op_sel]  <= s_value[6];
                            frate_reg[op_sel] <= s_value[5:0];
                        end
                    end
                    4'd2, 4'd6: freq_reg[op_sel][15:8] <= s_value;
                    4'd3: begin
                        freq_reg[0][22:16] <= {3'd0, s_value[3:0]};
                        dis_reg[0] <= s_value[7];
                    end
                    4'd7: begin
                        freq_reg[1][22:16] <= s_value[6:0];
                        dis_reg[1] <= s_value[7];
                    end
                    4'd5: begin
                        if (offset_mode == OFS_WAVE) ofs_wave_reg <= sh_r;
                        else if (offset_mode == OFS_OUT) ofs_out_reg <= sh_l;
                        else ofs_freq_reg <= sh_l;
                    end
                    4'd8: begin
                        mw_second_reg <= 1'b1;
                        mw_val_reg <= step_value(s_value[2:0]);
                        mwi_reg <= mwi_reg + AW'(1);
                    end
                    4'd9: begin
                        level_reg[0] <= s_value[1:0]; dis2_reg[0] <= s_value[7];
                    end
                    4'd10: begin
                        level_reg[1] <= s_value[1:0]; dis2_reg[1] <= s_value[7];
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            freq[i] = {freq_reg[i][22:8], 8'd0};
            frate[i] = frate_reg[i]; fdir_up[i] = fdir_reg[i]; fdis[i] = fdis_reg[i];
            level[i] = level_reg[i]; dis[i] = dis_reg[i]; dis2[i] = dis2_reg[i];
        end
    end
    assign ofs_freq = ofs_freq_reg;
    assign ofs_wave = ofs_wave_reg;
    assign ofs_out  = ofs_out_reg;
endmodule

// File: rtl/core/fmwt_queue.sv
// ----------------------------------------------------------------------------
// fmwt_queue
// Two-entry command queue between the front end and the execution unit.
// ----------------------------------------------------------------------------
module fmwt_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  fmwt_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output fmwt_pkg::cmd_t head
);
    import fmwt_pkg::*;

    cmd_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full      = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign head      = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= push_data;
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// File: rtl/core/fmwt_back.sv
// ----------------------------------------------------------------------------
// fmwt_back
// Execution unit: runs both operators on ticks with one shared multiplier.
// ----------------------------------------------------------------------------
module fmwt_back #(
    parameter int WAVE_DEPTH = fmwt_pkg::WAVE_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    input  fmwt_pkg::cmd_t q_head,
    output logic           q_pop,
    output logic           busy,
    output logic           exec_active,
    input  logic [31:0]    cycles_per_sample,
    input  logic [22:0]    cycles_per_frame,
    input  logic [22:0]    freq [2],
    input  logic [31:0]    ofs_freq,
    input  logic [31:0]    ofs_wave,
    input  logic [31:0]    ofs_out,
    input  logic [5:0]     frate [2],
    input  logic           fdir_up [2],
    input  logic           fdis [2],
    input  logic [5:0]     vol_load [2],
    input  logic           vol_load_en [2],
    input  logic [1:0]     level [2],
    input  logic           dis [2],
    input  logic           dis2 [2],
    input  logic           cw_we,
    input  logic [$clog2(WAVE_DEPTH)-1:0] cw_addr,
    input  logic [5:0]     cw_data,
    input  logic           mw_we,
    input  logic [$clog2(WAVE_DEPTH)-1:0] mw_addr,
    input  logic [3:0]     mw_data,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_read_data,
    output logic signed [31:0] m_sample
);
    import fmwt_pkg::*;
    localparam int AW = $clog2(WAVE_DEPTH);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FADE  = 7'b0000010,
        S_PMUL  = 7'b0000100,
        S_RD    = 7'b0001000,
        S_WAIT  = 7'b0010000,
        S_OMUL  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t      state_reg;
    logic        op_reg;          // 1 modulator, 0 carrier
    logic [31:0] phase_reg [2], timer_reg [2], fcount_reg [2];
    logic [5:0]  vol_reg [2];
    logic [31:0] mod_out_reg, acc_reg;
    logic        zero_reg;
    logic [5:0]  cwave_reg [WAVE_DEPTH];
    logic [3:0]  mwave_reg [WAVE_DEPTH];
    logic [5:0]  cw_q_reg;
    logic [3:0]  mw_q_reg;
    logic        out_full_reg;
    logic [7:0]  rd_reg;
    logic [31:0] smp_reg;
    logic [AW:0] init_reg;

    logic [31:0] tnew, fnew, thresh, input_v, eff, ma, mb, prod, wsample;

    // Carrier table starts as a square wave: sweep it once after reset.
    always_ff @(posedge aclk) begin
        if (init_reg != WAVE_DEPTH[AW:0]) begin
            cwave_reg[init_reg[AW-1:0]] <= init_reg[AW-1] ? 6'h20 : 6'h1f;
            mwave_reg[init_reg[AW-1:0]] <= 4'd0;
        end else begin
            if (cw_we) cwave_reg[cw_addr] <= cw_data;
            if (mw_we) mwave_reg[mw_addr] <= mw_data;
        end
        cw_q_reg <= cwave_reg[phase_reg[0][24 +: AW]];
        mw_q_reg <= mwave_reg[phase_reg[1][24 +: AW]];
    end

    assign tnew    = timer_reg[op_reg] + cycles_per_sample;
    assign fnew    = fcount_reg[op_reg] + {9'd0, cycles_per_frame};
    assign thresh  = {3'd0, ({1'b0, frate[op_reg]} + 7'd1), 22'd0} << 1;
    assign input_v = op_reg ? 32'd0 : (mod_out_reg << (5'd11 - {3'd0, level[1]}));
    assign eff     = {9'd0, freq[op_reg]} + input_v + (op_reg ? ofs_freq : 32'd0);
    assign wsample = op_reg ? {{28{mw_q_reg[3]}}, mw_q_reg}
                            : {{26{cw_q_reg[5]}}, cw_q_reg};
    always_comb begin
        if (state_reg == S_PMUL) begin
            ma = eff; mb = {16'd0, timer_reg[op_reg][31:16]};
        end else begin
            ma = wsample + (op_reg ? ofs_wave : 32'd0);
            mb = {26'd0, vol_reg[op_reg]};
        end
    end
    assign prod = ma * mb;

    // Busy only while the wave tables are being initialized.
    assign busy        = init_reg != WAVE_DEPTH[AW:0];
    assign exec_active = state_reg != S_IDLE;
    assign q_pop   = q_valid && state_reg == S_IDLE && !out_full_reg && !busy;
    assign m_valid = out_full_reg;
    assign m_read_data = rd_reg;
    assign m_sample    = smp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE; op_reg <= 1'b1; out_full_reg <= 1'b0;
            init_reg <= '0;
            for (int i = 0; i < 2; i++) begin
                phase_reg[i] <= '0; timer_reg[i] <= '0; fcount_reg[i] <= '0;
                vol_reg[i] <= '0;
            end
            mod_out_reg <= '0; zero_reg <= 1'b0;
        end else begin
            if (init_reg != WAVE_DEPTH[AW:0]) init_reg <= init_reg + 1'b1;
            for (int i = 0; i < 2; i++) begin
                if (vol_load_en[i]) vol_reg[i] <= vol_load[i];
            end
            if (m_valid && m_ready) out_full_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (q_pop) begin
                        rd_reg <= q_head.read_data;
                        smp_reg <= '0;
                        if (q_head.kind == CMD_TICK) begin
                            state_reg <= S_FADE; op_reg <= 1'b1;
                        end else begin
                            out_full_reg <= 1'b1;
                        end
                    end
                end
                S_FADE: begin
                    if (dis[op_reg]) begin
                        acc_reg <= '0;
                        state_reg <= S_DONE;
                    end else begin
                        if (!dis2[op_reg] && !fdis[op_reg]) begin
                            if (fnew >= thresh) begin
                                fcount_reg[op_reg] <= fnew - thresh;
                                if (fdir_up[op_reg]) begin
                                    if (vol_reg[op_reg] != 6'h3f)
                                        vol_reg[op_reg] <= vol_reg[op_reg] + 6'd1;
                                end else if (vol_reg[op_reg] != 6'd0) begin
                                    vol_reg[op_reg] <= vol_reg[op_reg] - 6'd1;
                                end
                            end else begin
                                fcount_reg[op_reg] <= fnew;
                            end
                        end
                        timer_reg[op_reg] <= tnew;
                        zero_reg <= {9'd0, freq[op_reg]} <= FREQ_MIN;
                        state_reg <= S_PMUL;
                    end
                end
                S_PMUL: begin
                    if (zero_reg) begin
                        acc_reg <= '0;
                        state_reg <= S_DONE;
                    end else begin
                        phase_reg[op_reg] <= phase_reg[op_reg] + prod;
                        timer_reg[op_reg] <= {16'd0, timer_reg[op_reg][15:0]};
                        state_reg <= S_RD;
                    end
                end
                S_RD:   state_reg <= S_WAIT;
                S_WAIT: state_reg <= S_OMUL;
                S_OMUL: begin
                    acc_reg <= (op_reg ? ofs_out : 32'd0) + prod;
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (op_reg) begin
                        mod_out_reg <= acc_reg;
                        op_reg <= 1'b0;
                        state_reg <= S_FADE;
                    end else begin
                        smp_reg <= acc_reg << (5'd11 - {3'd0, level[0]});
                        out_full_reg <= 1'b1;
                        op_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/core/fm_wavetable_sound_channel.sv
// ----------------------------------------------------------------------------
// fm_wavetable_sound_channel
// Two-operator wavetable sound channel with bus register interface.
// ----------------------------------------------------------------------------
// Each input transaction is a bus write, a bus read or a sample tick, and each
// one returns exactly one result transaction. Writes and reads are applied in
// the front end and queued; when the queue was empty, the execution unit idle
// and the output free, their result is offered from the output register once
// the command has passed through the queue. A tick runs the modulator and then
// the carrier through one shared multiplier, each operator stepping through the
// fade, phase multiply, table read, read wait, output multiply and finish
// states. A disabled operator goes from fade straight to finish, and one with a
// frequency of 0x20 or less from phase multiply to finish. Reads and ticks may
// wait in the two-entry queue behind a running tick, but a register write is
// held off until the queue is empty and the execution unit idle, because it
// changes state that the tick uses. A modulator table write blocks the input
// while its second entry is stored. After reset the carrier table is swept
// with its square wave, and no transaction is accepted while the sweep runs.
// Configuration writes take effect at once and belong in periods when no
// transaction is in flight.
module fm_wavetable_sound_channel #(
    parameter int WAVE_DEPTH = fmwt_pkg::WAVE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [15:0] s_address,
    input  logic [7:0]  s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic signed [31:0] m_sample,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import fmwt_pkg::*;

    logic [31:0] cps_reg;
    logic [22:0] cpf_reg;
    logic [1:0]  omode_reg;
    logic [3:0]  oshift_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cps_reg <= 32'd2661000; cpf_reg <= 23'd166000;
            omode_reg <= 2'd1; oshift_reg <= 4'd0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_CPS:   cps_reg <= cfg_data;
                CFG_CPF:   cpf_reg <= cfg_data[22:0];
                CFG_OMODE: omode_reg <= cfg_data[1:0];
                default:   oshift_reg <= cfg_data[3:0];
            endcase
        end
    end

    // Front end to queue and back end.
    logic q_full, q_push, q_ne, q_pop, busy, exec_active;
    cmd_t q_in, q_head;
    logic [22:0] freq [2];
    logic [31:0] ofs_freq, ofs_wave, ofs_out;
    logic [5:0]  frate [2], vol_load [2];
    logic        fdir_up [2], fdis [2], vol_load_en [2], dis [2], dis2 [2];
    logic [1:0]  level [2];
    logic        cw_we, mw_we;
    logic [$clog2(WAVE_DEPTH)-1:0] cw_addr, mw_addr;
    logic [5:0]  cw_data;
    logic [3:0]  mw_data;

    fmwt_front #(.WAVE_DEPTH(WAVE_DEPTH)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_req_type, .s_address, .s_value,
        .offset_mode(omode_reg), .offset_shift(oshift_reg),
        .q_full, .q_not_empty(q_ne), .q_push, .q_data(q_in), .busy, .exec_active,
        .freq, .ofs_freq, .ofs_wave, .ofs_out, .frate, .fdir_up, .fdis,
        .vol_load, .vol_load_en, .level, .dis, .dis2,
        .cw_we, .cw_addr, .cw_data, .mw_we, .mw_addr, .mw_data
    );

    fmwt_queue u_queue (
        .aclk, .aresetn, .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .not_empty(q_ne), .head(q_head)
    );

    fmwt_back #(.WAVE_DEPTH(WAVE_DEPTH)) u_back (
        .aclk, .aresetn, .q_valid(q_ne), .q_head, .q_pop, .busy, .exec_active,
        .cycles_per_sample(cps_reg), .cycles_per_frame(cpf_reg),
        .freq, .ofs_freq, .ofs_wave, .ofs_out, .frate, .fdir_up, .fdis,
        .vol_load, .vol_load_en, .level, .dis, .dis2,
        .cw_we, .cw_addr, .cw_data, .mw_we, .mw_addr, .mw_data,
        .m_valid, .m_ready, .m_read_data, .m_sample
    );
endmodule
